[design/trrt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the TCP receive reassembly tracker.
// No dependencies.
package trrt_pkg;

  localparam int unsigned RecvWindow   = 8192;
  localparam int unsigned BufBytes     = 65536;
  localparam int unsigned MaxSeg       = 1024;
  localparam int unsigned EarlyEntries = 16;
  localparam int unsigned DrainCap     = (BufBytes < 65536) ? BufBytes : 65536;

  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 11;
  localparam int unsigned CntW = 17;

  typedef enum logic [2:0] {
    VERDICT_OLD_DUP    = 3'd0,
    VERDICT_OUT_WINDOW = 3'd1,
    VERDICT_NO_SPACE   = 3'd2,
    VERDICT_IN_ORDER   = 3'd3,
    VERDICT_EARLY      = 3'd4,
    VERDICT_TABLE_FULL = 3'd5,
    VERDICT_UNACKED    = 3'd6,
    VERDICT_DRAINED    = 3'd7
  } verdict_e;

  typedef enum logic [1:0] {
    CELL_NONE,
    CELL_ABSORB,
    CELL_WR_MATCH,
    CELL_WR_FREE
  } cell_op_e;

  typedef struct packed {
    logic            kind;
    logic [SeqW-1:0] seq_num;
    logic [LenW-1:0] seg_len;
    logic [SeqW-1:0] ts_value;
  } word_in_t;

  typedef struct packed {
    verdict_e        verdict;
    logic            ack_valid;
    logic [SeqW-1:0] ack_number;
    logic [SeqW-1:0] ack_echo_ts;
    logic [SeqW-1:0] deliver_start;
    logic [CntW-1:0] deliver_count;
  } word_out_t;

  typedef struct packed {
    cell_op_e        op;
    logic [SeqW-1:0] key;
    logic [LenW-1:0] len;
  } cell_cmd_t;

  typedef struct packed {
    logic            mseen;
    logic            fseen;
    logic [LenW-1:0] mlen;
  } cell_chain_t;

endpackage

[design/trrt_cell.sv]
`timescale 1ns / 1ps
// One early-segment table entry with its link in the priority chain.
// Depends on trrt_pkg.
module trrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trrt_pkg::cell_cmd_t   cmd_i,
  input  trrt_pkg::cell_chain_t chain_i,
  output trrt_pkg::cell_chain_t chain_o
);

  logic                      valid_q;
  logic [trrt_pkg::SeqW-1:0] start_q;
  logic [trrt_pkg::LenW-1:0] len_q;
  logic                      hit, first_hit, first_free;

  assign hit        = valid_q && (start_q == cmd_i.key);
  assign first_hit  = hit && !chain_i.mseen;
  assign first_free = !valid_q && !chain_i.fseen;

  assign chain_o.mseen = chain_i.mseen | hit;
  assign chain_o.fseen = chain_i.fseen | !valid_q;
  assign chain_o.mlen  = first_hit ? len_q : chain_i.mlen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        trrt_pkg::CELL_ABSORB: begin
          if (first_hit) valid_q <= 1'b0;
        end
        trrt_pkg::CELL_WR_FREE: begin
          if (first_free) valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      trrt_pkg::CELL_WR_MATCH: begin
        if (first_hit) len_q <= cmd_i.len;
      end
      trrt_pkg::CELL_WR_FREE: begin
        if (first_free) begin
          start_q <= cmd_i.key;
          len_q   <= cmd_i.len;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/tcp_receive_reassembly_tracker.sv]
`timescale 1ns / 1ps
// Top level: sequencer for segment classification, drain and reassembly.
// Depends on trrt_pkg and trrt_cell.
//
// An item is taken when start is high and busy is low; its result comes on
// res_o with done_o high for one cycle and must be taken then. Drains, drops
// and old duplicates end in the exec state; an unacked duplicate passes
// exec and finish; an early segment passes exec, record and finish; an
// in-order segment passes exec, absorb for each table entry absorbed and
// once with no match, then finish; the chain resolves one absorb per cycle.
module tcp_receive_reassembly_tracker #(
  parameter int unsigned EARLY_ENTRIES = trrt_pkg::EarlyEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  trrt_pkg::word_in_t  word_i,
  output logic                done_o,
  output trrt_pkg::word_out_t res_o
);

  localparam int unsigned SeqW = trrt_pkg::SeqW;
  localparam int unsigned LenW = trrt_pkg::LenW;
  localparam int unsigned CntW = trrt_pkg::CntW;
  localparam logic [LenW:0]   MaxSegL  = (LenW+1)'(trrt_pkg::MaxSeg);
  localparam logic [SeqW-1:0] WinL     = SeqW'(trrt_pkg::RecvWindow);
  localparam logic [SeqW-1:0] BufL     = SeqW'(trrt_pkg::BufBytes);
  localparam logic [SeqW-1:0] DrainL   = SeqW'(trrt_pkg::DrainCap);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_ABSORB, ST_RECORD, ST_FINISH
  } state_e;

  state_e                state_q;
  logic                  kind_q;
  logic [SeqW-1:0]       seq_q, ts_q;
  logic [LenW-1:0]       len_q;
  logic [SeqW-1:0]       wl_q, ce_q, dn_q, rts_q;
  trrt_pkg::verdict_e    vd_q;
  logic                  done_q;
  trrt_pkg::word_out_t   res_q;

  trrt_pkg::cell_cmd_t   cmd;
  trrt_pkg::cell_chain_t chain [EARLY_ENTRIES+1];

  logic [LenW:0]   len_ext;
  logic [LenW-1:0] len_clamp;
  logic [SeqW-1:0] seg_end, pending, drain_cnt;
  logic            no_space;

  function automatic trrt_pkg::word_out_t pack_res(
    input trrt_pkg::verdict_e vd,
    input logic               av,
    input logic [SeqW-1:0]    an,
    input logic [SeqW-1:0]    ats,
    input logic [SeqW-1:0]    ds,
    input logic [CntW-1:0]    dc
  );
    trrt_pkg::word_out_t r;
    r.verdict       = vd;
    r.ack_valid     = av;
    r.ack_number    = an;
    r.ack_echo_ts   = ats;
    r.deliver_start = ds;
    r.deliver_count = dc;
    return r;
  endfunction

  assign len_ext   = {1'b0, word_i.seg_len};
  assign len_clamp = (len_ext > MaxSegL) ? MaxSegL[LenW-1:0] : word_i.seg_len;

  assign seg_end  = seq_q + SeqW'(len_q);
  assign no_space = ((ce_q >= dn_q) && (seg_end > dn_q + BufL)) ||
                    ((ce_q < dn_q) && (seg_end > dn_q));
  assign pending   = ce_q - dn_q;
  assign drain_cnt = (pending > DrainL) ? DrainL : pending;

  always_comb begin
    cmd.op  = trrt_pkg::CELL_NONE;
    cmd.key = seq_q;
    cmd.len = len_q;
    case (state_q)
      ST_ABSORB: begin
        cmd.op  = trrt_pkg::CELL_ABSORB;
        cmd.key = ce_q;
      end
      ST_RECORD: begin
        cmd.op = chain[EARLY_ENTRIES].mseen ? trrt_pkg::CELL_WR_MATCH
                                            : trrt_pkg::CELL_WR_FREE;
      end
      default: ;
    endcase
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < EARLY_ENTRIES; g++) begin : g_cell
    trrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      wl_q    <= '0;
      ce_q    <= '0;
      dn_q    <= '0;
      rts_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (kind_q) begin
            res_q   <= pack_res(trrt_pkg::VERDICT_DRAINED, 1'b0, '0, '0, dn_q,
                                drain_cnt[CntW-1:0]);
            dn_q    <= dn_q + drain_cnt;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (seq_q < wl_q) begin
            res_q   <= pack_res(trrt_pkg::VERDICT_OLD_DUP, 1'b1, wl_q, '0, '0, '0);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (seg_end > wl_q + WinL) begin
            res_q   <= pack_res(trrt_pkg::VERDICT_OUT_WINDOW, 1'b0, '0, '0, '0, '0);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (no_space) begin
            res_q   <= pack_res(trrt_pkg::VERDICT_NO_SPACE, 1'b0, '0, '0, '0, '0);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (seq_q == ce_q) begin
            rts_q   <= ts_q;
            ce_q    <= ce_q + SeqW'(len_q);
            vd_q    <= trrt_pkg::VERDICT_IN_ORDER;
            state_q <= ST_ABSORB;
          end else if (seq_q > ce_q) begin
            if (chain[EARLY_ENTRIES].mseen || chain[EARLY_ENTRIES].fseen) begin
              vd_q    <= trrt_pkg::VERDICT_EARLY;
              state_q <= ST_RECORD;
            end else begin
              res_q   <= pack_res(trrt_pkg::VERDICT_TABLE_FULL, 1'b0, '0, '0, '0, '0);
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else begin
            vd_q    <= trrt_pkg::VERDICT_UNACKED;
            state_q <= ST_FINISH;
          end
        end
        ST_ABSORB: begin
          if (chain[EARLY_ENTRIES].mseen) begin
            ce_q <= ce_q + SeqW'(chain[EARLY_ENTRIES].mlen);
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_RECORD: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          res_q   <= pack_res(vd_q, 1'b1, ce_q, rts_q, '0, '0);
          if (ce_q > wl_q) wl_q <= ce_q;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      kind_q <= word_i.kind;
      seq_q  <= word_i.seq_num;
      len_q  <= len_clamp;
      ts_q   <= word_i.ts_value;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[design/trrt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the TCP receive reassembly tracker, bound to the top.
// Depends on trrt_pkg and tcp_receive_reassembly_tracker.
module trrt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input trrt_pkg::word_out_t res_o
);

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  a_drop_noack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.verdict == trrt_pkg::VERDICT_OUT_WINDOW ||
               res_o.verdict == trrt_pkg::VERDICT_NO_SPACE ||
               res_o.verdict == trrt_pkg::VERDICT_TABLE_FULL ||
               res_o.verdict == trrt_pkg::VERDICT_DRAINED) |-> !res_o.ack_valid)
    else $error("ack on dropped or drain word");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result");

endmodule

bind tcp_receive_reassembly_tracker trrt_checker u_trrt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
